@@ rtl/dfs_pkg.sv @@
`timescale 1ns / 1ps
package dfs_pkg;

  localparam int unsigned DefMaxVertices = 64;
  localparam int unsigned DefMaxEdges    = 1024;

  localparam int unsigned VidW  = 7;
  localparam int unsigned ActW  = 2;
  localparam int unsigned StatW = 2;

  typedef enum logic [ActW-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_SORT  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_VID = 2'd2
  } status_e;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [VidW-1:0] source_vertex;
    logic [VidW-1:0] dest_vertex;
  } in_item_t;

  typedef struct packed {
    logic [VidW-1:0]  vertex_id;
    logic             last_item;
    logic [StatW-1:0] status;
  } out_item_t;

endpackage

@@ rtl/dfs_topological_sort.sv @@
`timescale 1ns / 1ps
// Clear and add items each return one result beat.
// A sort item walks each edge, each vertex reached and each root scanned, and then
// emits its result beats; the single edge-store read port paces the walk.
// Only one item is in flight; the next input beat is taken once all results are gone.
// Reset (rst_ni low, asynchronous) empties all lists, clears visited marks and counts,
// and sets vertex_count to 64. Edge and stack memories need no clearing pass.
module dfs_topological_sort #(
  parameter int unsigned MaxVertices = dfs_pkg::DefMaxVertices,
  parameter int unsigned MaxEdges    = dfs_pkg::DefMaxEdges
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  dfs_pkg::in_item_t       in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output dfs_pkg::out_item_t      out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [dfs_pkg::VidW-1:0] cfg_data_i
);
  import dfs_pkg::*;

  localparam int unsigned VW = $clog2(MaxVertices);     // vertex index width
  localparam int unsigned EW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned CW = $clog2(MaxEdges + 1);    // edge count width
  localparam int unsigned DW = $clog2(MaxVertices + 1); // depth / finish count width

  // The sequencer states. Each walk step reads one memory and acts on the registered
  // data the cycle after.
  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_ADD    = 14'b00000000000010,
    S_REPLY  = 14'b00000000000100,
    S_ROOT   = 14'b00000000001000,
    S_PUSH   = 14'b00000000010000,
    S_TOP    = 14'b00000000100000,
    S_TOPW   = 14'b00000001000000,
    S_EDGE   = 14'b00000010000000,
    S_EDGEW  = 14'b00000100000000,
    S_TGT    = 14'b00001000000000,
    S_EMIT   = 14'b00010000000000,
    S_EMITW  = 14'b00100000000000,
    S_EMPTY  = 14'b01000000000000,
    S_LINK   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [VidW-1:0] vcount_q;
  logic [MaxVertices-1:0] nonempty_q, visited_q;
  logic [CW-1:0] edges_q;
  logic [DW-1:0] depth_q, fcount_q, emit_q;
  logic [VW:0]   root_q;
  in_item_t      item_q;
  out_item_t     out_q;
  logic          out_valid_q;

  // Memories: edge target/link, list head/tail per vertex, stack and finish record.
  logic [VidW-1:0] etgt_mem [MaxEdges];
  logic [EW-1:0]   elink_mem [MaxEdges];
  logic [EW-1:0]   head_mem [MaxVertices];
  logic [EW-1:0]   tail_mem [MaxVertices];
  // Stack frame: vertex, cursor, more.
  logic [VidW-1:0] stk_v_mem [MaxVertices];
  logic [EW-1:0]   stk_c_mem [MaxVertices];
  logic            stk_m_mem [MaxVertices];
  logic [VidW-1:0] fin_mem [MaxVertices];

  logic [VidW-1:0] etgt_rd, fin_rd, top_v, stk_v_rd;
  logic [EW-1:0]   elink_rd, head_rd, tail_rd, stk_c_rd, top_c, top_tail;
  logic            stk_m_rd, top_m;

  // Registers for the edge being linked and the vertex about to be pushed.
  logic [EW-1:0]   cur_e;
  logic [VidW-1:0] new_v;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  function automatic logic vid_ok(input logic [VidW-1:0] v);
    return (v != '0) && ({25'd0, v} <= MaxVertices);
  endfunction

  logic [VW-1:0] src_idx, new_idx, top_idx, root_idx;
  assign src_idx  = VW'(item_q.source_vertex - 7'd1);
  assign new_idx  = VW'(new_v - 7'd1);
  assign top_idx  = VW'(top_v - 7'd1);
  assign root_idx = root_q[VW-1:0];

  logic [VidW:0] roots;
  assign roots = ({25'd0, vcount_q} > MaxVertices) ? (VidW+1)'(MaxVertices)
                                                   : {1'b0, vcount_q};

  logic tgt_ok;
  assign tgt_ok = vid_ok(etgt_rd) && !visited_q[VW'(etgt_rd - 7'd1)]
                  && ({{(32-DW){1'b0}}, depth_q} < MaxVertices);

  // Memory ports, all clocked.
  logic            mem_add;
  logic            stk_we;
  logic [VW-1:0]   stk_wa;
  logic [VidW-1:0] stk_wv;
  logic [EW-1:0]   stk_wc;
  logic            stk_wm;
  logic [VW-1:0]   stk_ra;
  logic [VW-1:0]   list_ra;
  logic [EW-1:0]   edge_ra;
  logic [VW-1:0]   fin_ra;
  logic            fin_we;

  always_ff @(posedge clk_i) begin
    if (mem_add) begin
      etgt_mem[EW'(edges_q)]  <= item_q.dest_vertex;
      elink_mem[EW'(edges_q)] <= '0;
      tail_mem[src_idx]       <= EW'(edges_q);
      if (!nonempty_q[src_idx]) begin
        head_mem[src_idx] <= EW'(edges_q);
      end
    end
    if (state_q == S_LINK) begin
      elink_mem[tail_rd] <= cur_e;
    end
    if (stk_we) begin
      stk_v_mem[stk_wa] <= stk_wv;
      stk_c_mem[stk_wa] <= stk_wc;
      stk_m_mem[stk_wa] <= stk_wm;
    end
    if (fin_we) begin
      fin_mem[VW'(fcount_q)] <= top_v;
    end
    etgt_rd  <= etgt_mem[edge_ra];
    elink_rd <= elink_mem[edge_ra];
    head_rd  <= head_mem[list_ra];
    tail_rd  <= tail_mem[list_ra];
    stk_v_rd <= stk_v_mem[stk_ra];
    stk_c_rd <= stk_c_mem[stk_ra];
    stk_m_rd <= stk_m_mem[stk_ra];
    fin_rd   <= fin_mem[fin_ra];
  end

  // Address selection. The stack is read below the cached top frame, so that a
  // pop in S_TOPW finds the parent frame ready in S_EDGE.
  always_comb begin
    stk_ra  = VW'(depth_q - DW'(2));
    edge_ra = top_c;
    fin_ra  = VW'(fcount_q - emit_q - DW'(1));
    unique case (state_q)
      S_PUSH:  list_ra = new_idx;
      S_TOP,
      S_TOPW,
      S_EDGE,
      S_EDGEW: list_ra = top_idx;
      default: list_ra = src_idx;
    endcase
  end

  // The frame at the top of the stack is cached in registers.
  logic [VidW-1:0] top_v_q;
  logic [EW-1:0]   top_c_q;
  logic            top_m_q;
  assign top_v = top_v_q;
  assign top_c = top_c_q;
  assign top_m = top_m_q;
  assign top_tail = tail_rd;

  always_comb begin
    state_d = state_q;
    mem_add = 1'b0;
    stk_we  = 1'b0;
    stk_wa  = VW'(depth_q);
    stk_wv  = top_v_q;
    stk_wc  = top_c_q;
    stk_wm  = top_m_q;
    fin_we  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data_i.action)
            ACT_CLEAR: state_d = S_REPLY;
            ACT_ADD:   state_d = S_ADD;
            ACT_SORT:  state_d = S_ROOT;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        // Tail read for the source list issues now and is used in S_LINK; link or first edge.
        if (vid_ok(item_q.source_vertex) && vid_ok(item_q.dest_vertex)
            && ({{(32-CW){1'b0}}, edges_q} < MaxEdges)) begin
          mem_add = 1'b1;
          state_d = nonempty_q[src_idx] ? S_LINK : S_REPLY;
        end else begin
          state_d = S_REPLY;
        end
      end
      S_LINK:  state_d = S_REPLY;
      S_REPLY: if (!out_valid_q) state_d = S_IDLE;
      S_ROOT: begin
        if ({1'b0, root_q} >= roots) begin
          state_d = (fcount_q == '0) ? S_EMPTY : S_EMITW;
        end else if (!visited_q[root_idx]) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH:  state_d = S_TOP;
      S_TOP: begin
        // Head read done for the new vertex.
        state_d = S_TOPW;
      end
      S_TOPW: begin
        if (top_m_q) begin
          state_d = S_EDGEW;
        end else begin
          fin_we  = ({{(32-DW){1'b0}}, fcount_q} < MaxVertices);
          state_d = (depth_q == DW'(1)) ? S_ROOT : S_EDGE;
        end
      end
      S_EDGE: state_d = S_TOPW; // reload popped frame
      S_EDGEW: state_d = S_TGT;
      S_TGT: begin
        if (tgt_ok) begin
          stk_we  = 1'b1;
          stk_wa  = VW'(depth_q - DW'(1));
          stk_wc  = elink_rd;
          stk_wm  = (top_c_q != tail_rd);
          state_d = S_PUSH;
        end else begin
          state_d = S_TOPW;
        end
      end
      S_EMITW: state_d = S_EMIT;
      S_EMIT: begin
        if (!out_valid_q) state_d = (emit_q + DW'(1) == fcount_q) ? S_IDLE : S_EMITW;
      end
      S_EMPTY: if (!out_valid_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcount_q    <= 7'd64;
      nonempty_q  <= '0;
      visited_q   <= '0;
      edges_q     <= '0;
      depth_q     <= '0;
      fcount_q    <= '0;
      emit_q      <= '0;
      root_q      <= '0;
      out_valid_q <= 1'b0;
      top_m_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) vcount_q <= cfg_data_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && in_data_i.action == ACT_CLEAR) begin
            nonempty_q <= '0;
            edges_q    <= '0;
            out_q      <= '{vertex_id: '0, last_item: 1'b1, status: ST_OK};
          end
          if (in_fire && in_data_i.action == ACT_SORT) begin
            visited_q <= '0;
            fcount_q  <= '0;
            emit_q    <= '0;
            root_q    <= '0;
            depth_q   <= '0;
          end
        end
        S_ADD: begin
          cur_e <= EW'(edges_q);
          if (!(vid_ok(item_q.source_vertex) && vid_ok(item_q.dest_vertex))) begin
            out_q <= '{vertex_id: '0, last_item: 1'b1, status: ST_BAD_VID};
          end else if ({{(32-CW){1'b0}}, edges_q} >= MaxEdges) begin
            out_q <= '{vertex_id: '0, last_item: 1'b1, status: ST_FULL};
          end else begin
            out_q <= '{vertex_id: '0, last_item: 1'b1, status: ST_OK};
            nonempty_q[src_idx] <= 1'b1;
            edges_q <= edges_q + CW'(1);
          end
        end
        S_REPLY: if (!out_valid_q) out_valid_q <= 1'b1;
        S_ROOT: begin
          if (!({1'b0, root_q} >= roots)) begin
            if (!visited_q[root_idx]) new_v <= VidW'(root_q) + 7'd1;
            root_q <= root_q + (VW+1)'(1);
          end
        end
        S_PUSH: begin
          visited_q[new_idx] <= 1'b1;
          top_v_q <= new_v;
        end
        S_TOP: begin
          top_m_q <= nonempty_q[top_idx];
          top_c_q <= head_rd;
          depth_q <= depth_q + DW'(1);
        end
        S_TOPW: begin
          if (!top_m_q) begin
            if ({{(32-DW){1'b0}}, fcount_q} < MaxVertices) fcount_q <= fcount_q + DW'(1);
            depth_q <= depth_q - DW'(1);
          end
        end
        S_EDGE: begin
          top_v_q <= stk_v_rd;
          top_c_q <= stk_c_rd;
          top_m_q <= stk_m_rd;
        end
        S_TGT: begin
          top_m_q <= (top_c_q != tail_rd);
          top_c_q <= elink_rd;
          if (tgt_ok) new_v <= etgt_rd;
        end
        S_EMIT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_q <= '{vertex_id: fin_rd, last_item: (emit_q + DW'(1) == fcount_q),
                       status: ST_OK};
            emit_q <= emit_q + DW'(1);
          end
        end
        S_EMPTY: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_q <= '{vertex_id: '0, last_item: 1'b1, status: ST_OK};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) item_q <= in_data_i;
  end

  logic unused;
  assign unused = ^{top_tail, stk_wm, top_m};

  // The emit read address follows emit_q and the read is registered: S_EMITW waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({{(32-DW){1'b0}}, depth_q} <= MaxVertices)) else $error("stack overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !out_valid_q) |=> out_valid_q) else $error("emit lost");
endmodule
